// File: rtl/ffha_pkg.sv
// Shared constants and command and status codes of the first-fit heap allocator.
package ffha_pkg;
   localparam int HEAP_WORDS   = 4096;
   localparam int HEADER_BYTES = 4;
   localparam int IDX_W        = $clog2(HEAP_WORDS);
   localparam int BADDR_W      = 18;

   localparam logic [2:0] CMD_INIT    = 3'd0;
   localparam logic [2:0] CMD_ALLOC   = 3'd1;
   localparam logic [2:0] CMD_CALLOC  = 3'd2;
   localparam logic [2:0] CMD_REALLOC = 3'd3;
   localparam logic [2:0] CMD_FREE    = 3'd4;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOFIT    = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;

   localparam logic       CSR_HEAP_START = 1'b0;
   localparam logic       CSR_HEAP_END   = 1'b1;

   typedef logic [BADDR_W-1:0] baddr_type;
endpackage

// File: rtl/ffha_ram.sv
// Generic single-port RAM with registered read data.
module ffha_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule

// File: rtl/first_fit_heap_allocator_top.sv
// Top level of the first-fit heap allocator: sequencer, header store and CSRs.
//
// Usage: load heap_start (index 0) and heap_end (index 1) through the csr_
// write port, then issue init before any other command. A command beat is
// taken when start is high and busy is low; busy stays high until the result
// beat, which is shown for one cycle with rsp_strobe. The receiver cannot
// stall, so the result must be captured in that cycle.
// Steps: init writes the header at heap_start; alloc walks the headers
// first-fit and takes the first free block that fits; calloc first checks
// count times size for overflow; free clears the used word and merges the
// free blocks that follow until the heap end, a used block or an oversize merge
// ends it; realloc keeps the block when it fits, grows it in place into a
// free neighbour, or else frees it and walks the headers again.
// The single port of the header store sets the rate: one word is read or
// written per cycle, and each visited header costs two reads and a decision.
// One command is in work at a time; the next may start the cycle after the
// result beat. Reset returns the sequencer to idle and the registers to
// heap_start 0 and heap_end 8192; the store is not cleared, so init must run
// first.
module first_fit_heap_allocator_top
   import ffha_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_cmd,
   input  logic [15:0] req_size,
   input  logic [15:0] req_count,
   input  logic [15:0] req_block_pointer,
   output logic        rsp_strobe,
   output logic [15:0] rsp_result_pointer,
   output logic [1:0]  rsp_status,
   output logic        rsp_copy_needed,
   output logic [15:0] rsp_copy_from,
   output logic [15:0] rsp_copy_length,
   output logic        rsp_zero_needed,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);
   localparam logic [4:0] S_IDLE = 5'd0,  S_INIT0 = 5'd1,  S_INIT1 = 5'd2,
                          S_CAL  = 5'd3,  S_W0    = 5'd4,  S_W1    = 5'd5,
                          S_W2   = 5'd6,  S_T0    = 5'd7,  S_T1    = 5'd8,
                          S_T2   = 5'd9,  S_T3    = 5'd10, S_F0    = 5'd11,
                          S_F1   = 5'd12, S_F2    = 5'd13, S_F3    = 5'd14,
                          S_F4   = 5'd15, S_FE    = 5'd16, S_R0    = 5'd17,
                          S_R1   = 5'd18, S_R2    = 5'd19, S_R3    = 5'd20,
                          S_R4   = 5'd21, S_G0    = 5'd22, S_G1    = 5'd23,
                          S_G2   = 5'd24, S_DONE  = 5'd25;

   localparam baddr_type HDR = baddr_type'(HEADER_BYTES);

   logic [4:0]  state_ff, state_in;
   logic [15:0] heap_start_ff, heap_end_ff;
   logic [2:0]  cmd_ff;
   logic [16:0] m_ff, m_in;
   logic [15:0] bp_ff, ph_ff, hs_ff, hs_in, sz_ff, sz_in;
   baddr_type   addr_ff, addr_in, bs_ff, bs_in;
   logic        used_ff, used_in, split_ff, split_in, cz_ff;
   logic [31:0] prod_ff;
   logic [15:0] res_ptr_ff, res_ptr_in;
   logic [1:0]  status_ff, status_in;
   logic        copy_ff, copy_in, zero_ff, zero_in;

   baddr_type   mem_baddr, heap_end_x, ph_x, t_sum, nx_sum, ns;
   logic        mem_we, in_range, rd_ok_ff;
   logic [15:0] mem_wd, ram_q, rd;
   logic [16:0] s_init;

   assign heap_end_x = baddr_type'(heap_end_ff);
   assign ph_x       = baddr_type'(ph_ff);
   assign in_range   = mem_baddr[BADDR_W-1:1] < (BADDR_W-1)'(HEAP_WORDS);
   assign rd         = rd_ok_ff ? ram_q : 16'd0;
   assign ns         = split_ff ? baddr_type'(m_ff) : bs_ff;
   assign s_init     = ({1'b0, heap_end_ff} >= {1'b0, heap_start_ff} + 17'd4) ?
                       ({1'b0, heap_end_ff} - {1'b0, heap_start_ff} - 17'd4) : 17'd0;

   ffha_ram #(.WIDTH(16), .DEPTH(HEAP_WORDS)) u_store (
      .clock (clock),
      .we    (mem_we && in_range),
      .addr  (mem_baddr[IDX_W:1]),
      .wdata (mem_wd),
      .rdata (ram_q)
   );

   always_comb begin
      state_in   = state_ff;
      m_in       = m_ff;
      hs_in      = hs_ff;
      sz_in      = sz_ff;
      addr_in    = addr_ff;
      bs_in      = bs_ff;
      used_in    = used_ff;
      split_in   = split_ff;
      res_ptr_in = res_ptr_ff;
      status_in  = status_ff;
      copy_in    = copy_ff;
      zero_in    = zero_ff;
      mem_baddr  = addr_ff;
      mem_we     = 1'b0;
      mem_wd     = 16'd0;
      t_sum      = baddr_type'(sz_ff) + baddr_type'(rd) + HDR;
      nx_sum     = ph_x + baddr_type'(rd) + HDR;
      unique case (state_ff)
         S_IDLE: ;
         S_INIT0: begin
            mem_baddr = baddr_type'(heap_start_ff);
            mem_we    = 1'b1;
            state_in  = S_INIT1;
         end
         S_INIT1: begin
            mem_baddr = baddr_type'(heap_start_ff) + 18'd2;
            mem_we    = 1'b1;
            mem_wd    = s_init[15:0];
            state_in  = S_DONE;
         end
         S_CAL: begin
            if (cz_ff) begin
               m_in     = 17'd0;
               state_in = S_W0;
            end else if (prod_ff[31:16] != 16'd0) begin
               status_in = ST_OVERFLOW;
               state_in  = S_DONE;
            end else begin
               m_in     = ({1'b0, prod_ff[15:0]} + 17'd1) & ~17'd1;
               state_in = S_W0;
            end
         end
         S_W0: begin
            if (addr_ff >= heap_end_x) begin
               status_in = ST_NOFIT;
               state_in  = S_DONE;
            end else begin
               state_in = S_W1;
            end
         end
         S_W1: begin
            mem_baddr = addr_ff + 18'd2;
            used_in   = rd[7:0] != 8'd0;
            state_in  = S_W2;
         end
         S_W2: begin
            if (!used_ff && {1'b0, rd} >= m_ff) begin
               bs_in    = baddr_type'(rd);
               state_in = S_T0;
            end else begin
               addr_in  = addr_ff + baddr_type'(rd) + HDR;
               state_in = S_W0;
            end
         end
         S_T0: begin
            mem_baddr = addr_ff + HDR + baddr_type'(m_ff);
            split_in  = baddr_type'(m_ff) + HDR <= bs_ff;
            mem_we    = split_in;
            state_in  = split_in ? S_T1 : S_T2;
         end
         S_T1: begin
            mem_baddr = addr_ff + HDR + baddr_type'(m_ff) + 18'd2;
            mem_we    = 1'b1;
            mem_wd    = 16'(bs_ff - baddr_type'(m_ff) - HDR);
            state_in  = S_T2;
         end
         S_T2: begin
            mem_we   = 1'b1;
            mem_wd   = 16'd1;
            state_in = S_T3;
         end
         S_T3: begin
            mem_baddr  = addr_ff + 18'd2;
            mem_we     = 1'b1;
            mem_wd     = ns[15:0];
            res_ptr_in = 16'(addr_ff + HDR);
            zero_in    = (cmd_ff == CMD_CALLOC) && !cz_ff;
            copy_in    = cmd_ff == CMD_REALLOC;
            state_in   = S_DONE;
         end
         S_F0: begin
            mem_baddr = ph_x + 18'd2;
            state_in  = S_F1;
         end
         S_F1: begin
            mem_baddr = ph_x;
            mem_we    = 1'b1;
            sz_in     = rd;
            addr_in   = nx_sum;
            state_in  = S_F2;
         end
         S_F2: begin
            state_in = (addr_ff < heap_end_x) ? S_F3 : S_FE;
         end
         S_F3: begin
            mem_baddr = addr_ff + 18'd2;
            used_in   = rd[7:0] != 8'd0;
            state_in  = S_F4;
         end
         S_F4: begin
            if (used_ff || t_sum[17:16] != 2'd0) begin
               state_in = S_FE;
            end else begin
               sz_in    = t_sum[15:0];
               addr_in  = ph_x + t_sum + HDR;
               state_in = S_F2;
            end
         end
         S_FE: begin
            mem_baddr = ph_x + 18'd2;
            mem_we    = 1'b1;
            mem_wd    = sz_ff;
            addr_in   = baddr_type'(heap_start_ff);
            state_in  = (cmd_ff == CMD_REALLOC) ? S_W0 : S_DONE;
         end
         S_R0: begin
            mem_baddr = ph_x + 18'd2;
            state_in  = S_R1;
         end
         S_R1: begin
            hs_in   = rd;
            addr_in = nx_sum;
            if (m_ff <= {1'b0, rd}) begin
               res_ptr_in = bp_ff;
               state_in   = S_DONE;
            end else if (nx_sum < heap_end_x) begin
               state_in = S_R2;
            end else begin
               state_in = S_F0;
            end
         end
         S_R2: begin
            state_in = S_R3;
         end
         S_R3: begin
            mem_baddr = addr_ff + 18'd2;
            used_in   = rd[7:0] != 8'd0;
            state_in  = S_R4;
         end
         S_R4: begin
            bs_in = baddr_type'(hs_ff) + baddr_type'(rd) + HDR;
            if (!used_ff && bs_in >= baddr_type'(m_ff)) begin
               split_in = baddr_type'(m_ff) + HDR <= bs_in;
               state_in = split_in ? S_G0 : S_G2;
            end else begin
               state_in = S_F0;
            end
         end
         S_G0: begin
            mem_baddr = ph_x + HDR + baddr_type'(m_ff);
            mem_we    = 1'b1;
            state_in  = S_G1;
         end
         S_G1: begin
            mem_baddr = ph_x + HDR + baddr_type'(m_ff) + 18'd2;
            mem_we    = 1'b1;
            mem_wd    = 16'(bs_ff - baddr_type'(m_ff) - HDR);
            state_in  = S_G2;
         end
         S_G2: begin
            mem_baddr  = ph_x + 18'd2;
            mem_we     = 1'b1;
            mem_wd     = (ns[17:16] != 2'd0) ? 16'hFFFF : ns[15:0];
            res_ptr_in = bp_ff;
            state_in   = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         heap_start_ff <= 16'd0;
         heap_end_ff   <= 16'd8192;
         rd_ok_ff      <= 1'b0;
      end else begin
         rd_ok_ff <= in_range;
         if (csr_we) begin
            unique case (csr_index)
               CSR_HEAP_START: heap_start_ff <= csr_wdata;
               CSR_HEAP_END:   heap_end_ff   <= csr_wdata;
               default: ;
            endcase
         end
         if (start && !busy) begin
            unique case (req_cmd)
               CMD_INIT:    state_ff <= S_INIT0;
               CMD_ALLOC:   state_ff <= S_W0;
               CMD_CALLOC:  state_ff <= S_CAL;
               CMD_REALLOC: state_ff <= S_R0;
               CMD_FREE:    state_ff <= S_F0;
               default:     state_ff <= S_DONE;
            endcase
         end else begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         cmd_ff     <= req_cmd;
         m_ff       <= ({1'b0, req_size} + 17'd1) & ~17'd1;
         bp_ff      <= req_block_pointer;
         ph_ff      <= req_block_pointer - 16'd4;
         addr_ff    <= baddr_type'(heap_start_ff);
         prod_ff    <= {16'd0, req_count} * {16'd0, req_size};
         cz_ff      <= (req_count == 16'd0) || (req_size == 16'd0);
         res_ptr_ff <= 16'd0;
         status_ff  <= ST_OK;
         copy_ff    <= 1'b0;
         zero_ff    <= 1'b0;
      end else begin
         m_ff       <= m_in;
         addr_ff    <= addr_in;
         res_ptr_ff <= res_ptr_in;
         status_ff  <= status_in;
         copy_ff    <= copy_in;
         zero_ff    <= zero_in;
      end
      hs_ff    <= hs_in;
      sz_ff    <= sz_in;
      bs_ff    <= bs_in;
      used_ff  <= used_in;
      split_ff <= split_in;
   end

   assign busy               = state_ff != S_IDLE;
   assign rsp_strobe         = state_ff == S_DONE;
   assign rsp_result_pointer = res_ptr_ff;
   assign rsp_status         = status_ff;
   assign rsp_copy_needed    = copy_ff;
   assign rsp_copy_from      = copy_ff ? bp_ff : 16'd0;
   assign rsp_copy_length    = copy_ff ? hs_ff : 16'd0;
   assign rsp_zero_needed    = zero_ff;

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("result beat longer than one cycle");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("command beat not taken");
   a_fail_null: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status != ST_OK |-> rsp_result_pointer == 16'd0
         && !rsp_copy_needed && !rsp_zero_needed) else $error("failed beat carries a block");
   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_copy_needed && rsp_zero_needed)) else $error("copy and zero both set");
endmodule
